>>> src/fl2db_pkg.sv
// Shared constants and helpers for the linear-to-decibel converter.
`timescale 1ns / 1ps
package fl2db_pkg;

	localparam logic [63:0] K_OFFSET = 64'd533544524211;
	localparam logic [63:0] K_SLOPE  = 64'd6433991156;
	localparam logic [63:0] K_NUM    = 64'd7412598114;
	localparam logic [63:0] K_BIAS   = 64'd1512209481;

	localparam logic [23:0] K_SCALE20 = 24'd6313057;

	localparam logic signed [18:0] LEVEL_MAX = 19'sd200000;
	localparam logic signed [18:0] LEVEL_MIN = -19'sd200000;

	localparam int LEVEL_W = 19;
	localparam int OUT_TDATA_W = 24;

	function automatic logic [63:0] to_qf(input logic [63:0] k, input int f);
		return (k + (64'd1 << (31 - f))) >> (32 - f);
	endfunction

endpackage

>>> src/fl2db_front.sv
// Input stage: coarse log2, mantissa slope term and divisor for the divider chain.
`timescale 1ns / 1ps
module fl2db_front #(
	parameter int F = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [31:0]     sample_bits,
	output logic            out_valid,
	output logic [F:0]      div,
	output logic [F+9:0]    side
);

	localparam int CW = F + 8;
	localparam int LW = F + 10;

	localparam logic [63:0] C0 = fl2db_pkg::to_qf(fl2db_pkg::K_OFFSET, F);
	localparam logic [63:0] C1 = fl2db_pkg::to_qf(fl2db_pkg::K_SLOPE, F);
	localparam logic [63:0] C3 = fl2db_pkg::to_qf(fl2db_pkg::K_BIAS, F);

	logic [30:0]    mag;
	logic [22:0]    mant;
	logic [F-1:0]   m;
	logic [CW-1:0]  coarse;
	logic [2*F:0]   prod;
	logic [F:0]     c1_w;

	logic [CW-1:0]  coarse_s1;
	logic [F:0]     t1_s1;
	logic [F:0]     div_s1;
	logic           vld_s1;

	assign mag  = sample_bits[30:0];
	assign mant = sample_bits[22:0];
	assign c1_w = C1[F:0];

	generate
		if (F >= 24) begin : g_m_wide
			assign m = F'(1) << (F - 1) | (F'(mant) << (F - 24));
		end else begin : g_m_narrow
			assign m = {1'b1, mant[22:24-F]};
		end
		if (F >= 23) begin : g_c_wide
			assign coarse = CW'(mag) << (F - 23);
		end else begin : g_c_narrow
			assign coarse = CW'(mag >> (23 - F));
		end
	endgenerate

	assign prod = c1_w * m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coarse_s1 <= coarse;
			t1_s1     <= prod[2*F:F];
			div_s1    <= C3[F:0] + {1'b0, m};
		end
	end

	assign out_valid = vld_s1;
	assign div       = div_s1;
	assign side      = $signed(LW'(coarse_s1)) - $signed(C0[LW-1:0]) - $signed(LW'(t1_s1));

endmodule

>>> src/fl2db_div_cell.sv
// One restoring-division cell: resolves one quotient bit per cycle while en is high and passes the rest on.
`timescale 1ns / 1ps
module fl2db_div_cell #(
	parameter int RW = 25,
	parameter int QW = 26,
	parameter int SW = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [RW-1:0] in_rem,
	input  logic [RW-1:0] in_div,
	input  logic [QW-1:0] in_quo,
	input  logic [SW-1:0] in_side,
	input  logic          in_bit,
	output logic          out_valid,
	output logic [RW-1:0] out_rem,
	output logic [RW-1:0] out_div,
	output logic [QW-1:0] out_quo,
	output logic [SW-1:0] out_side
);

	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          ge;

	logic          vld_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] div_q;
	logic [QW-1:0] quo_q;
	logic [SW-1:0] side_q;

	assign trial = {in_rem, in_bit};
	assign ge    = trial >= {1'b0, in_div};
	assign diff  = trial - {1'b0, in_div};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[RW-1:0] : trial[RW-1:0];
			div_q  <= in_div;
			quo_q  <= {in_quo[QW-2:0], ge};
			side_q <= in_side;
		end
	end

	assign out_valid = vld_q;
	assign out_rem   = rem_q;
	assign out_div   = div_q;
	assign out_quo   = quo_q;
	assign out_side  = side_q;

endmodule

>>> src/fl2db_back.sv
// Output stages: final log2, split scaling multiply, rounding and saturation.
`timescale 1ns / 1ps
module fl2db_back #(
	parameter int F = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [F+1:0]                         quo,
	input  logic [F+9:0]                         side,
	output logic                                 out_valid,
	output logic signed [fl2db_pkg::LEVEL_W-1:0] level
);

	localparam int LW = F + 10;
	localparam int PW = F + 34;
	localparam logic [PW-1:0] RND = PW'(1) << (F + 11);

	logic signed [LW-1:0]   l_s1;
	logic                   vld_s1;
	logic signed [LW+7:0]   hi_s2;
	logic [39:0]            lo_s2;
	logic                   vld_s2;
	logic signed [PW-1:0]   sum_s3;
	logic                   vld_s3;
	logic signed [fl2db_pkg::LEVEL_W-1:0] lvl_s4;
	logic                   vld_s4;

	logic signed [21:0]     lvl;

	assign lvl = 22'(sum_s3 >>> (F + 12));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1   <= $signed(side) - $signed(LW'(quo));
			hi_s2  <= $signed(l_s1[LW-1:16]) * $signed(fl2db_pkg::K_SCALE20);
			lo_s2  <= l_s1[15:0] * fl2db_pkg::K_SCALE20;
			sum_s3 <= ($signed(PW'(hi_s2)) <<< 16) + $signed(PW'(lo_s2)) + $signed(RND);
			if (lvl > fl2db_pkg::LEVEL_MAX) begin
				lvl_s4 <= fl2db_pkg::LEVEL_MAX;
			end else if (lvl < fl2db_pkg::LEVEL_MIN) begin
				lvl_s4 <= fl2db_pkg::LEVEL_MIN;
			end else begin
				lvl_s4 <= lvl[fl2db_pkg::LEVEL_W-1:0];
			end
		end
	end

	assign out_valid = vld_s4;
	assign level     = lvl_s4;

endmodule

>>> src/fast_linear_to_db_top.sv
// Path: the front stage, then the divider cell chain, then the back stages, input beat to output beat.
// Throughput: one beat per cycle; the divider is a chain of FRACTION_BITS + 2 cells,
// one quotient bit each, so every stage takes a new beat each cycle.
// All stages hold together while an output beat waits for m_tready.
// Reset: arst_n clears only the valid flags; data registers are not reset.
`timescale 1ns / 1ps
module fast_linear_to_db_top #(
	parameter int FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [fl2db_pkg::OUT_TDATA_W-1:0] m_tdata  // [18:0] level_db, rest zero
);

	localparam int F  = FRACTION_BITS;
	localparam int QW = F + 2;
	localparam int RW = F + 1;
	localparam int LW = F + 10;

	localparam logic [63:0] C2 = fl2db_pkg::to_qf(fl2db_pkg::K_NUM, F);
	localparam logic [QW-1:0] DIV_BITS = QW'(C2[1:0]) << F;
	localparam logic [RW-1:0] REM_INIT = RW'(C2 >> 2);

	logic                en;
	logic                f_valid;
	logic [RW-1:0]       f_div;
	logic [LW-1:0]       f_side;

	logic                c_valid [QW+1];
	logic [RW-1:0]       c_rem   [QW+1];
	logic [RW-1:0]       c_div   [QW+1];
	logic [QW-1:0]       c_quo   [QW+1];
	logic [LW-1:0]       c_side  [QW+1];

	logic signed [fl2db_pkg::LEVEL_W-1:0] level;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	fl2db_front #(
		.F(F)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.sample_bits(s_tdata),
		.out_valid  (f_valid),
		.div        (f_div),
		.side       (f_side)
	);

	assign c_valid[0] = f_valid;
	assign c_rem[0]   = REM_INIT;
	assign c_div[0]   = f_div;
	assign c_quo[0]   = '0;
	assign c_side[0]  = f_side;

	generate
		for (genvar i = 0; i < QW; i++) begin : g_cell
			fl2db_div_cell #(
				.RW(RW),
				.QW(QW),
				.SW(LW)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (c_valid[i]),
				.in_rem   (c_rem[i]),
				.in_div   (c_div[i]),
				.in_quo   (c_quo[i]),
				.in_side  (c_side[i]),
				.in_bit   (DIV_BITS[QW-1-i]),
				.out_valid(c_valid[i+1]),
				.out_rem  (c_rem[i+1]),
				.out_div  (c_div[i+1]),
				.out_quo  (c_quo[i+1]),
				.out_side (c_side[i+1])
			);
		end
	endgenerate

	fl2db_back #(
		.F(F)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (c_valid[QW]),
		.quo      (c_quo[QW]),
		.side     (c_side[QW]),
		.out_valid(m_tvalid),
		.level    (level)
	);

	assign m_tdata = {{(fl2db_pkg::OUT_TDATA_W - fl2db_pkg::LEVEL_W){1'b0}}, level};

endmodule
